>>> hdl/sdtq_pkg.sv
// shared types and constants of the sorted delay timer queue
package sdtq_pkg;

    localparam int DELAY_W  = 32;
    localparam int HANDLE_W = 16;

    localparam logic [DELAY_W-1:0] TICK_STEP_RESET = 32'd16666666;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RESET = 32'd17000000;
    localparam logic [DELAY_W-1:0] NEXT_TICK_DELAY = 32'd1;

    typedef enum logic [0:0] {
        ACT_SCHEDULE = 1'b0,
        ACT_TICK     = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_EXPIRED  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_TICK_STEP = 1'b0,
        CFG_MIN_DELAY = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_SUB    = 2'd3
    } cell_op_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        cell_op_t            op;
        logic [DELAY_W-1:0]  key;
        logic [DELAY_W-1:0]  step;
    } cell_ctrl_t;

endpackage

>>> hdl/sdtq_intf.sv
// handshake channels of the sorted delay timer queue
interface sdtq_req_if;
    logic                              valid;
    logic                              ready;
    sdtq_pkg::action_t                 action;
    logic [sdtq_pkg::DELAY_W-1:0]      delay_ns;
    logic [sdtq_pkg::HANDLE_W-1:0]     handle;

    modport source (output valid, action, delay_ns, handle, input ready);
    modport sink   (input valid, action, delay_ns, handle, output ready);
endinterface

interface sdtq_rsp_if;
    logic                              valid;
    logic                              ready;
    sdtq_pkg::kind_t                   kind;
    logic [sdtq_pkg::HANDLE_W-1:0]     expired_handle;
    logic                              last;

    modport source (output valid, kind, expired_handle, last, input ready);
    modport sink   (input valid, kind, expired_handle, last, output ready);
endinterface

interface sdtq_cfg_if;
    logic                              valid;
    logic                              ready;
    sdtq_pkg::cfg_index_t              index;
    logic [sdtq_pkg::DELAY_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sdtq_cell.sv
// one slot of the sorted queue: delay and handle, shifts with its neighbors
module sdtq_cell #(
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  sdtq_pkg::cell_ctrl_t              ctrl,
    input  logic                              occ,
    input  logic                              left_ge,
    input  logic [HANDLE_BITS-1:0]            new_handle,
    input  logic [sdtq_pkg::DELAY_W-1:0]      left_delay,
    input  logic [HANDLE_BITS-1:0]            left_handle,
    input  logic [sdtq_pkg::DELAY_W-1:0]      right_delay,
    input  logic [HANDLE_BITS-1:0]            right_handle,
    output logic [sdtq_pkg::DELAY_W-1:0]      delay,
    output logic [HANDLE_BITS-1:0]            handle,
    output logic                              ge,
    output logic                              exp
);

    logic [sdtq_pkg::DELAY_W-1:0] delay_reg;
    logic [sdtq_pkg::DELAY_W-1:0] delay_next;
    logic [HANDLE_BITS-1:0]       handle_reg;
    logic [HANDLE_BITS-1:0]       handle_next;

    // empty slots count as greater, so a new entry lands after the last one
    assign ge  = !occ || (delay_reg >= ctrl.key);
    assign exp = occ && (delay_reg <= ctrl.step);

    always_comb
    begin
        delay_next  = delay_reg;
        handle_next = handle_reg;
        unique case (ctrl.op)
            sdtq_pkg::CELL_INSERT:
            begin
                if (left_ge)
                begin
                    delay_next  = left_delay;
                    handle_next = left_handle;
                end
                else if (ge)
                begin
                    delay_next  = ctrl.key;
                    handle_next = new_handle;
                end
            end
            sdtq_pkg::CELL_POP:
            begin
                delay_next  = right_delay;
                handle_next = right_handle;
            end
            sdtq_pkg::CELL_SUB:
            begin
                if (occ)
                begin
                    delay_next = delay_reg - ctrl.step;
                end
            end
            default:
            begin
                delay_next  = delay_reg;
                handle_next = handle_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        delay_reg  <= delay_next;
        handle_reg <= handle_next;
    end

    assign delay  = delay_reg;
    assign handle = handle_reg;

endmodule

>>> hdl/sorted_delay_timer_queue_unit.sv
// top level of the sorted delay timer queue: control, config and cell row
// usage
//   req carries one item: a schedule (delay_ns, handle) or a tick
//   rsp carries results: expired handles, or accepted / rejected status
//   cfg writes tick_step_ns (index 0) and min_delay_ns (index 1); the user
//   writes only while the block is idle (unchecked); cfg.ready is always high
// timing
//   a schedule: the item is latched; once the output register is free,
//   the row inserts it in one step unless full and registers its status
//   a tick: while the output register is free, the front cell pops one
//   expired entry per cycle into it, then one pass subtracts the step in
//   every cell at once
//   one item is in work at a time; the rate is set by the front cell,
//   which hands out one expired entry per cycle while rsp is not held off
// reset
//   the queue comes up empty with the register defaults; cell storage
//   is not cleared, only the entry count
// stall
//   while rsp is held off, the output register keeps its item and pops
//   and inserts wait; a waiting finished item does not keep a new one out
module sorted_delay_timer_queue_unit #(
    parameter int CAPACITY    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sdtq_req_if.sink    req,
    sdtq_rsp_if.source  rsp,
    sdtq_cfg_if.sink    cfg
);

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int HW        = sdtq_pkg::HANDLE_W;
    localparam int DW        = sdtq_pkg::DELAY_W;
    localparam int KEEP_BITS = (HANDLE_BITS < HW) ? HANDLE_BITS : HW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_POP
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sdtq_pkg::kind_t      out_kind_reg;
    sdtq_pkg::kind_t      out_kind_next;
    logic [HW-1:0]        out_handle_reg;
    logic [HW-1:0]        out_handle_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic [DW-1:0]        key_reg;
    logic [DW-1:0]        key_next;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [HANDLE_BITS-1:0] hnd_next;
    logic [DW-1:0]        tick_step_reg;
    logic [DW-1:0]        min_delay_reg;

    logic                 slot_free;
    logic                 accept;
    logic                 full;
    sdtq_pkg::cell_ctrl_t ctrl;

    logic [DW-1:0]          cell_delay  [CAPACITY];
    logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
    logic [CAPACITY-1:0]    cell_ge;
    logic [CAPACITY-1:0]    cell_exp;
    logic [CAPACITY-1:0]    cell_occ;

    // output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || rsp.ready;
    // taking an item only latches it; the output register is needed later
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg <= sdtq_pkg::TICK_STEP_RESET;
            min_delay_reg <= sdtq_pkg::MIN_DELAY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                sdtq_pkg::CFG_TICK_STEP: tick_step_reg <= cfg.data;
                sdtq_pkg::CFG_MIN_DELAY: min_delay_reg <= cfg.data;
                default:                 tick_step_reg <= tick_step_reg;
            endcase
        end
    end

    // broadcast command to the cell row
    always_comb
    begin
        ctrl.op   = sdtq_pkg::CELL_HOLD;
        ctrl.key  = key_reg;
        ctrl.step = tick_step_reg;
        unique case (state_reg)
            S_INSERT:
            begin
                if (slot_free && !full)
                begin
                    ctrl.op = sdtq_pkg::CELL_INSERT;
                end
            end
            S_POP:
            begin
                if (!cell_exp[0])
                begin
                    ctrl.op = sdtq_pkg::CELL_SUB;
                end
                else if (slot_free)
                begin
                    ctrl.op = sdtq_pkg::CELL_POP;
                end
            end
            default:
            begin
                ctrl.op = sdtq_pkg::CELL_HOLD;
            end
        endcase
    end

    // sequencer: next state, entry count and output register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        key_next        = key_reg;
        hnd_next        = hnd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == sdtq_pkg::ACT_TICK)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                        // short delays fire on the next tick
                        key_next   = (req.delay_ns <= min_delay_reg) ?
                                     sdtq_pkg::NEXT_TICK_DELAY : req.delay_ns;
                        hnd_next   = HANDLE_BITS'(req.handle[KEEP_BITS-1:0]);
                    end
                end
            end
            S_INSERT:
            begin
                if (slot_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_kind_next   = full ? sdtq_pkg::KIND_REJECTED :
                                             sdtq_pkg::KIND_ACCEPTED;
                    out_handle_next = HW'(hnd_reg[KEEP_BITS-1:0]);
                    out_last_next   = 1'b1;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_POP:
            begin
                if (!cell_exp[0])
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = sdtq_pkg::KIND_EXPIRED;
                    out_handle_next = HW'(cell_handle[0][KEEP_BITS-1:0]);
                    // the next cell moves to the front; last if it stays
                    out_last_next   = !cell_exp[1];
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
        key_reg        <= key_next;
        hnd_reg        <= hnd_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.expired_handle = out_handle_reg;
    assign rsp.last           = out_last_reg;

    // row of cells, front of the queue at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                   left_ge;
        logic [DW-1:0]          left_delay;
        logic [HANDLE_BITS-1:0] left_handle;
        logic [DW-1:0]          right_delay;
        logic [HANDLE_BITS-1:0] right_handle;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_ge     = 1'b0;
            assign left_delay  = key_reg;
            assign left_handle = hnd_reg;
        end
        else
        begin : g_mid
            assign left_ge     = cell_ge[i-1];
            assign left_delay  = cell_delay[i-1];
            assign left_handle = cell_handle[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_delay  = cell_delay[i];
            assign right_handle = cell_handle[i];
        end
        else
        begin : g_inner
            assign right_delay  = cell_delay[i+1];
            assign right_handle = cell_handle[i+1];
        end

        sdtq_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occ          (cell_occ[i]),
            .left_ge      (left_ge),
            .new_handle   (hnd_reg),
            .left_delay   (left_delay),
            .left_handle  (left_handle),
            .right_delay  (right_delay),
            .right_handle (right_handle),
            .delay        (cell_delay[i]),
            .handle       (cell_handle[i]),
            .ge           (cell_ge[i]),
            .exp          (cell_exp[i])
        );
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_idle_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed while idle");

    a_pop_only_expired: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == sdtq_pkg::CELL_POP) |-> (cell_exp[0] && cell_occ[0]))
        else $error("pop of an entry that has not expired");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_kind_reg) &&
                                           $stable(out_handle_reg) && $stable(out_last_reg)))
        else $error("result changed while stalled");
`endif

endmodule

>>> tb/sorted_delay_timer_queue_unit_test.sv
// self-checking testbench of the sorted delay timer queue unit
module sorted_delay_timer_queue_unit_test;

    localparam int CAPACITY      = 16;
    // a tick with nothing to expire gives no result, and the subtract pass
    // runs in the cycle after the last pop, so give the row this long to go idle
    localparam int SETTLE_CYCLES = 8;
    // cycles without any handshake on any channel before giving up
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        sdtq_pkg::kind_t                   kind;
        logic [sdtq_pkg::HANDLE_W-1:0]     handle;
        logic                              last;
    } timer_result_t;

    // one directed item; typed rows carry a kind that is obvious at a glance,
    // with the item's own handle and last set
    typedef struct packed {
        sdtq_pkg::action_t                 act;
        logic [sdtq_pkg::DELAY_W-1:0]      delay;
        logic [sdtq_pkg::HANDLE_W-1:0]     handle;
        logic                              typed;
        sdtq_pkg::kind_t                   kind;
    } probe_row_t;

    // runs with the register defaults: step 16666666, threshold 17000000
    localparam probe_row_t PROBES [23] = '{
        // tick on empty queue
        '{sdtq_pkg::ACT_TICK,     32'd0,         16'h0000, 1'b0, sdtq_pkg::KIND_EXPIRED},
        // zero delay, stored as 1
        '{sdtq_pkg::ACT_SCHEDULE, 32'd0,         16'h0000, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // widest delay and handle
        '{sdtq_pkg::ACT_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // exactly at threshold
        '{sdtq_pkg::ACT_SCHEDULE, 32'd17000000,  16'h0001, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // just above threshold
        '{sdtq_pkg::ACT_SCHEDULE, 32'd17000001,  16'h0002, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd16666666,  16'h5555, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd16666667,  16'hAAAA, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // survives one tick by 1
        '{sdtq_pkg::ACT_SCHEDULE, 32'd33333333,  16'h0003, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // lands on step after tick
        '{sdtq_pkg::ACT_SCHEDULE, 32'd33333332,  16'h0004, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd1,         16'h0005, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd50000000,  16'h0006, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd55555555,  16'h0007, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'hAAAA_AAAA, 16'h0008, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // equal key goes in front
        '{sdtq_pkg::ACT_SCHEDULE, 32'd17000000,  16'h0009, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd100000000, 16'h000A, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_SCHEDULE, 32'd80000000,  16'h000B, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // queue now full
        '{sdtq_pkg::ACT_SCHEDULE, 32'd20000000,  16'h000C, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        // full queue
        '{sdtq_pkg::ACT_SCHEDULE, 32'd12345678,  16'h00FF, 1'b1, sdtq_pkg::KIND_REJECTED},
        // six next-tick timers
        '{sdtq_pkg::ACT_TICK,     32'hFFFF_FFFF, 16'hFFFF, 1'b0, sdtq_pkg::KIND_EXPIRED},
        '{sdtq_pkg::ACT_TICK,     32'd0,         16'h0000, 1'b0, sdtq_pkg::KIND_EXPIRED},
        // room again
        '{sdtq_pkg::ACT_SCHEDULE, 32'd0,         16'h7FFF, 1'b1, sdtq_pkg::KIND_ACCEPTED},
        '{sdtq_pkg::ACT_TICK,     32'd0,         16'h0000, 1'b0, sdtq_pkg::KIND_EXPIRED},
        '{sdtq_pkg::ACT_TICK,     32'd0,         16'h0000, 1'b0, sdtq_pkg::KIND_EXPIRED}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sdtq_req_if req_ch ();
    sdtq_rsp_if rsp_ch ();
    sdtq_cfg_if cfg_ch ();

    sorted_delay_timer_queue_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the pending timers, sorted by remaining delay
    logic [sdtq_pkg::DELAY_W-1:0]  pending_delay  [CAPACITY];
    logic [sdtq_pkg::HANDLE_W-1:0] pending_handle [CAPACITY];
    int                            pending_count = 0;
    logic [sdtq_pkg::DELAY_W-1:0]  step_ns;
    logic [sdtq_pkg::DELAY_W-1:0]  floor_ns;
    // results owed by the block, oldest first
    timer_result_t                 due_results [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;   // random gaps and stalls allowed
    int calm_items   = 0;      // sender items left in a stretch with no gaps
    int stall_left   = 0;
    int calm_cycles  = 0;      // receiver cycles left in a stretch with no stalls

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // applies one accepted item to the shadow queue and queues its results
    function automatic void advance_timers(input sdtq_pkg::action_t act,
                                           input logic [sdtq_pkg::DELAY_W-1:0] dly,
                                           input logic [sdtq_pkg::HANDLE_W-1:0] hnd);
        logic [sdtq_pkg::DELAY_W-1:0] stored;
        int                           pos;
        int                           split;
        int                           i;
        if (act == sdtq_pkg::ACT_SCHEDULE)
        begin
            if (pending_count >= CAPACITY)
            begin
                due_results.push_back('{sdtq_pkg::KIND_REJECTED, hnd, 1'b1});
            end
            else
            begin
                // short delays fire on the very next tick
                stored = (dly <= floor_ns) ? sdtq_pkg::NEXT_TICK_DELAY : dly;
                pos = 0;
                while (pos < pending_count && pending_delay[pos] < stored)
                    pos++;
                for (i = pending_count; i > pos; i--)
                begin
                    pending_delay[i]  = pending_delay[i-1];
                    pending_handle[i] = pending_handle[i-1];
                end
                pending_delay[pos]  = stored;
                pending_handle[pos] = hnd;
                pending_count++;
                due_results.push_back('{sdtq_pkg::KIND_ACCEPTED, hnd, 1'b1});
            end
        end
        else
        begin
            // queue is sorted, so the expired timers are a prefix
            split = 0;
            while (split < pending_count && pending_delay[split] <= step_ns)
                split++;
            for (i = 0; i < split; i++)
                due_results.push_back('{sdtq_pkg::KIND_EXPIRED, pending_handle[i],
                                        i == split - 1});
            // survivors all exceed the step, so no wrap here
            for (i = split; i < pending_count; i++)
            begin
                pending_delay[i-split]  = pending_delay[i] - step_ns;
                pending_handle[i-split] = pending_handle[i];
            end
            pending_count -= split;
        end
    endfunction

    // delays spread around small multiples of the step, plus the edges
    function automatic logic [sdtq_pkg::DELAY_W-1:0] pick_delay();
        longint unsigned span;
        int unsigned     r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 12)
            return '1;
        if (r < 17)
            return floor_ns;
        if (r < 22)
            return floor_ns + 1;
        if (r < 30 || step_ns == 0)
            return (step_ns == 0 && r >= 30) ?
                   sdtq_pkg::DELAY_W'($urandom_range(0, 100)) : $urandom;
        span = 64'(step_ns) * 64'($urandom_range(0, 5)) + 64'($urandom_range(0, step_ns));
        return (span > 64'hFFFF_FFFF) ? '1 : span[sdtq_pkg::DELAY_W-1:0];
    endfunction

    // offers one item and holds it until taken; valid stays high afterwards
    task automatic push_item(input sdtq_pkg::action_t act,
                             input logic [sdtq_pkg::DELAY_W-1:0] dly,
                             input logic [sdtq_pkg::HANDLE_W-1:0] hnd);
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.delay_ns <= dly;
        req_ch.handle   <= hnd;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        advance_timers(act, dly, hnd);
    endtask

    // stop sending until every owed result is in and the row has gone quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender side idling before an item: rare drain, short bursts, calm runs
    task automatic hold_off();
        if (idle_on)
        begin
            if ($urandom_range(0, 59) == 0)
                settle();
            else if (calm_items > 0)
                calm_items--;
            else if ($urandom_range(0, 24) == 0)
                calm_items = $urandom_range(10, 40);
            else if ($urandom_range(0, 3) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // writes both registers back to back; only called with the block idle
    task automatic load_regs(input logic [sdtq_pkg::DELAY_W-1:0] step,
                             input logic [sdtq_pkg::DELAY_W-1:0] min_ns);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sdtq_pkg::CFG_TICK_STEP;
        cfg_ch.data  <= step;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        step_ns = step;
        cfg_ch.index <= sdtq_pkg::CFG_MIN_DELAY;
        cfg_ch.data  <= min_ns;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        floor_ns = min_ns;
        cfg_ch.valid <= 1'b0;
    endtask

    // one register setting followed by a run of random items
    task automatic run_phase(input logic [sdtq_pkg::DELAY_W-1:0] step,
                             input logic [sdtq_pkg::DELAY_W-1:0] min_ns,
                             input int count, input bit idle);
        sdtq_pkg::action_t act;
        settle();
        load_regs(step, min_ns);
        idle_on = idle;
        repeat (count)
        begin
            hold_off();
            // lean toward ticks once the queue is close to full
            act = ($urandom_range(0, 99) < (pending_count >= 12 ? 55 : 35)) ?
                  sdtq_pkg::ACT_TICK : sdtq_pkg::ACT_SCHEDULE;
            push_item(act, pick_delay(), sdtq_pkg::HANDLE_W'($urandom));
        end
    endtask

    // receiver side: random stall bursts, with calm stretches
    always @(posedge clk)
    begin
        if (!idle_on || calm_cycles != 0)
        begin
            if (calm_cycles != 0)
                calm_cycles <= calm_cycles - 1;
            rsp_ch.ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                calm_cycles <= $urandom_range(30, 120);
            rsp_ch.ready <= 1'b1;
        end
    end

    // result checker: every accepted result against the oldest owed one
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with nothing owed: kind %0d handle %h last %b",
                       rsp_ch.kind, rsp_ch.expired_handle, rsp_ch.last);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
                    fail_count++;
                end
                if (rsp_ch.expired_handle !== want.handle)
                begin
                    $error("expired_handle: expected %h, got %h",
                           want.handle, rsp_ch.expired_handle);
                    fail_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, rsp_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.action   = sdtq_pkg::ACT_SCHEDULE;
        req_ch.delay_ns = '0;
        req_ch.handle   = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = sdtq_pkg::CFG_TICK_STEP;
        cfg_ch.data     = '0;
        step_ns         = sdtq_pkg::TICK_STEP_RESET;
        floor_ns        = sdtq_pkg::MIN_DELAY_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table under the reset register values
        foreach (PROBES[i])
        begin
            hold_off();
            push_item(PROBES[i].act, PROBES[i].delay, PROBES[i].handle);
            // a schedule owes exactly one result; use the typed one instead
            if (PROBES[i].typed)
                due_results[due_results.size()-1] = '{PROBES[i].kind, PROBES[i].handle, 1'b1};
        end

        // register sweeps: tiny step, everything-next-tick, frozen time,
        // mid range, random, then defaults with no idling at all
        run_phase(32'd1, 32'd0, 70, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 1'b1);
        run_phase(32'd0, $urandom, 40, 1'b1);
        run_phase(32'd1000, 32'd2500, 80, 1'b1);
        run_phase($urandom_range(1000, 1 << 24), $urandom_range(0, 1 << 25), 100, 1'b1);
        run_phase(sdtq_pkg::TICK_STEP_RESET, sdtq_pkg::MIN_DELAY_RESET, 100, 1'b0);

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
